FILE: design/zero_padded_2d_correlation_top_assert.svh
// Assertion macros shared by the correlation block.
`ifndef ZERO_PADDED_2D_CORRELATION_TOP_ASSERT_SVH
`define ZERO_PADDED_2D_CORRELATION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ZP2C_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ZP2C_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/zp2c_pkg.sv
// Types, constants and helpers of the 2-D correlation block.
`timescale 1ns / 1ps
package zp2c_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 12;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int SUM_W     = 32;
   localparam int ROW_REG_W = 60;
   localparam int KSIZE_W   = 3;
   localparam int DIM_W     = 11;
   localparam int CSR_IDX_W = 3;
   localparam int COEF_ROWS = 5;

   typedef logic signed [SAMPLE_W-1:0]  sample_type;
   typedef logic signed [COEF_W-1:0]    coef_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef logic signed [SUM_W-1:0]     sum_type;
   typedef logic        [ROW_REG_W-1:0] coef_row_type;
   typedef logic        [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes
   localparam csr_idx_type CSR_TAP_COUNT    = 3'd0;
   localparam csr_idx_type CSR_IMAGE_WIDTH  = 3'd1;
   localparam csr_idx_type CSR_IMAGE_HEIGHT = 3'd2;
   localparam csr_idx_type CSR_COEF_ROW0    = 3'd3;
   localparam csr_idx_type CSR_COEF_ROW1    = 3'd4;
   localparam csr_idx_type CSR_COEF_ROW2    = 3'd5;
   localparam csr_idx_type CSR_COEF_ROW3    = 3'd6;
   localparam csr_idx_type CSR_COEF_ROW4    = 3'd7;

   // per-cell controls
   typedef struct packed {
      logic shift;  // take neighbor's sample
      logic load;   // product stage advances
      logic tap;    // tap lies inside kernel and image
   } cell_ctrl_type;

   // tap l of a packed coefficient row
   function automatic coef_type coef_tap(input coef_row_type row, input logic [2:0] l);
      coef_type t;
      case (l)
         3'd0:    t = row[11:0];
         3'd1:    t = row[23:12];
         3'd2:    t = row[35:24];
         3'd3:    t = row[47:36];
         3'd4:    t = row[59:48];
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: design/zp2c_cell.sv
// One window cell: holds a sample, passes it on, forms its tap product.
`timescale 1ns / 1ps
module zp2c_cell (
   input  logic                   clock,
   input  zp2c_pkg::cell_ctrl_type ctrl,
   input  zp2c_pkg::sample_type   din,
   input  zp2c_pkg::coef_type     coef,
   output zp2c_pkg::sample_type   dout,
   output zp2c_pkg::prod_type     prod
);
   import zp2c_pkg::*;

   sample_type sample_ff;
   prod_type   prod_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         sample_ff <= din;
      end
      if (ctrl.load) begin
         prod_ff <= ctrl.tap ? prod_type'(sample_ff * coef) : '0;
      end
   end

   assign dout = sample_ff;
   assign prod = prod_ff;

endmodule

FILE: design/zp2c_line.sv
// Line store: sample history read back a fixed number of rows behind.
`timescale 1ns / 1ps
module zp2c_line #(
   parameter int AW   = 12,
   parameter int WW   = 11,
   parameter int DIST = 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  zp2c_pkg::sample_type wr_data,
   input  logic [WW-1:0]        width,
   output zp2c_pkg::sample_type rd_data
);
   import zp2c_pkg::*;

   sample_type            mem [0:(2**AW)-1];
   sample_type            rd_data_ff;
   logic [AW+WW-1:0]      offset;
   logic [AW-1:0]         rd_addr;

   // DIST rows back at the current width
   assign offset  = (AW+WW)'(DIST) * (AW+WW)'(width);
   assign rd_addr = wr_addr - offset[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
         rd_data_ff   <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/zero_padded_2d_correlation_top.sv
// Top level of the zero-padded 2-D correlation block.
//
//  channel | direction | beat
//  --------+-----------+-------------------------------------------------
//  req_    | in        | func (sample or drain), sample (Q7.8)
//  rsp_    | out       | filtered_value (Q.16 sum), last_of_frame
//  csr_    | in        | index (register 0..7), data (up to 60 bits)
//
// One beat per cycle in and one result per cycle out while rsp_ is not
// stalled; a result reaches rsp_ through the line store read, window shift,
// tap products, row sums and output register.
// Each window row past the newest has its own line store and read port, so
// all rows are fetched in the same cycle and set the one-beat-per-cycle rate.
// Reset is synchronous; it sets config to its defaults and clears positions and pipeline flags.
// A stalled result freezes the whole pipeline; req_ready follows.
// csr_ready is always high.
`timescale 1ns / 1ps
`include "zero_padded_2d_correlation_top_assert.svh"
module zero_padded_2d_correlation_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  zp2c_pkg::sample_type         req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output zp2c_pkg::sum_type            rsp_filtered_value,
   output logic                         rsp_last_of_frame,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  zp2c_pkg::csr_idx_type        csr_index,
   input  zp2c_pkg::coef_row_type       csr_data
);
   import zp2c_pkg::*;

   localparam int HMAX = MAX_KERNEL / 2;
   localparam int ROWS = 2 * HMAX + 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int QW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * HMAX * (MAX_WIDTH + 1) + 1) + 1;
   localparam int AW   = $clog2(2 * HMAX * MAX_WIDTH + 2);

   // ---------------- configuration ----------------
   logic [KSIZE_W-1:0] ksize_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   coef_row_type       coef_ff [0:COEF_ROWS-1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ksize_ff  <= KSIZE_W'(3);
         width_ff  <= DIM_W'(1024);
         height_ff <= DIM_W'(1024);
         for (int n = 0; n < COEF_ROWS; n++) begin
            coef_ff[n] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TAP_COUNT:    ksize_ff   <= csr_data[KSIZE_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff   <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_data[DIM_W-1:0];
            CSR_COEF_ROW0:    coef_ff[0] <= csr_data;
            CSR_COEF_ROW1:    coef_ff[1] <= csr_data;
            CSR_COEF_ROW2:    coef_ff[2] <= csr_data;
            CSR_COEF_ROW3:    coef_ff[3] <= csr_data;
            CSR_COEF_ROW4:    coef_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end

   // clamped geometry
   logic [KSIZE_W-1:0] ks;
   logic [1:0]         h;
   logic [2:0]         two_h;
   logic [31:0]        w_full;
   logic [31:0]        hgt_full;
   logic [WW-1:0]      w_val;
   logic [HW-1:0]      hgt;
   logic [WW+HW-1:0]   total_full;
   logic [QW-1:0]      total;
   logic [PW-1:0]      delay;

   always_comb begin
      if (ksize_ff == '0) begin
         ks = KSIZE_W'(1);
      end else if (32'(ksize_ff) > 32'(MAX_KERNEL)) begin
         ks = KSIZE_W'(MAX_KERNEL);
      end else begin
         ks = ksize_ff;
      end
      if (width_ff == '0) begin
         w_full = 32'd1;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_full = 32'(MAX_WIDTH);
      end else begin
         w_full = 32'(width_ff);
      end
      if (height_ff == '0) begin
         hgt_full = 32'd1;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         hgt_full = 32'(MAX_HEIGHT);
      end else begin
         hgt_full = 32'(height_ff);
      end
   end

   assign h          = ks[2:1];
   assign two_h      = {h, 1'b0};
   assign w_val      = w_full[WW-1:0];
   assign hgt        = hgt_full[HW-1:0];
   assign total_full = {{HW{1'b0}}, w_val} * {{WW{1'b0}}, hgt};
   assign total      = total_full[QW-1:0];
   assign delay      = PW'(h) * PW'(w_val) + PW'(h);

   // ---------------- positions ----------------
   logic [PW-1:0] p_ff, p_in;
   logic [QW-1:0] q_ff, q_in;
   logic [HW-1:0] r_ff, r_in;
   logic [WW-1:0] c_ff, c_in;
   logic          adv;
   logic          accept;
   logic          due;
   logic          overrun;
   logic          res;
   logic          last;
   sample_type    value;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   assign due     = p_ff >= delay;
   assign overrun = due && (q_ff >= total);
   assign res     = due && !overrun;
   assign last    = res && (q_ff == total - QW'(1));
   assign value   = (!req_func && (p_ff < PW'(total))) ? req_sample : '0;

   always_comb begin
      p_in = p_ff;
      q_in = q_ff;
      r_in = r_ff;
      c_in = c_ff;
      if (accept) begin
         if (overrun || last) begin
            p_in = '0;
            q_in = '0;
            r_in = '0;
            c_in = '0;
         end else begin
            p_in = p_ff + PW'(1);
            if (res) begin
               q_in = q_ff + QW'(1);
               if (c_ff == w_val - WW'(1)) begin
                  c_in = '0;
                  r_in = r_ff + HW'(1);
               end else begin
                  c_in = c_ff + WW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= '0;
         q_ff <= '0;
         r_ff <= '0;
         c_ff <= '0;
      end else begin
         p_ff <= p_in;
         q_ff <= q_in;
         r_ff <= r_in;
         c_ff <= c_in;
      end
   end

   // rows and columns of the window that fall inside kernel and image
   logic [ROWS-1:0]    row_en;
   logic [ROWS-1:0]    col_en;
   logic signed [15:0] kk_t;
   logic signed [15:0] rr_t;
   logic signed [15:0] cc_t;

   always_comb begin
      row_en = '0;
      col_en = '0;
      kk_t   = '0;
      rr_t   = '0;
      cc_t   = '0;
      for (int j = 0; j < ROWS; j++) begin
         kk_t = 16'(two_h) - 16'(j);
         rr_t = 16'(r_ff) + 16'(h) - 16'(j);
         cc_t = 16'(c_ff) + 16'(h) - 16'(j);
         row_en[j] = (kk_t >= 0) && (kk_t < $signed(16'(ks))) &&
                     (rr_t >= 0) && (rr_t < $signed(16'(hgt)));
         col_en[j] = (kk_t >= 0) && (kk_t < $signed(16'(ks))) &&
                     (cc_t >= 0) && (cc_t < $signed(16'(w_val)));
      end
   end

   // ---------------- stage A: store write and row fetch ----------------
   logic            a_val_ff, a_res_ff, a_last_ff;
   logic [ROWS-1:0] a_row_ff, a_col_ff;
   sample_type      s0_ff;
   sample_type      line_out [0:ROWS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_val_ff <= 1'b0;
         a_res_ff <= 1'b0;
      end else if (adv) begin
         a_val_ff <= accept;
         a_res_ff <= accept && res;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_last_ff <= last;
         a_row_ff  <= row_en;
         a_col_ff  <= col_en;
         s0_ff     <= value;
      end
   end

   assign line_out[0] = s0_ff;

   for (genvar j = 1; j < ROWS; j++) begin : g_line
      zp2c_line #(
         .AW   (AW),
         .WW   (WW),
         .DIST (j)
      ) u_line (
         .clock   (clock),
         .wr_en   (accept),
         .wr_addr (p_ff[AW-1:0]),
         .wr_data (value),
         .width   (w_val),
         .rd_data (line_out[j])
      );
   end

   // ---------------- stage B: window shift; stage C: products ----------------
   logic            b_res_ff, b_last_ff;
   logic [ROWS-1:0] b_row_ff, b_col_ff;
   logic            c_res_ff, c_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_res_ff <= 1'b0;
         c_res_ff <= 1'b0;
      end else if (adv) begin
         b_res_ff <= a_res_ff;
         c_res_ff <= b_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_last_ff <= a_last_ff;
         b_row_ff  <= a_row_ff;
         b_col_ff  <= a_col_ff;
         c_last_ff <= b_last_ff;
      end
   end

   sample_type cell_q [0:ROWS-1][0:ROWS-1];
   prod_type   prod   [0:ROWS-1][0:ROWS-1];

   for (genvar j = 0; j < ROWS; j++) begin : g_row
      for (genvar i = 0; i < ROWS; i++) begin : g_col
         cell_ctrl_type ctrl;
         coef_type      coef;
         logic [2:0]    kk;
         logic [2:0]    ll;

         // cell (j,i) holds the sample j rows and i columns back,
         // which meets kernel tap (2h-j, 2h-i)
         assign kk         = two_h - 3'(j);
         assign ll         = two_h - 3'(i);
         assign ctrl.shift = a_val_ff && adv;
         assign ctrl.load  = adv;
         assign ctrl.tap   = b_row_ff[j] && b_col_ff[i];
         assign coef       = (kk < 3'(COEF_ROWS)) ? coef_tap(coef_ff[kk], ll) : '0;

         if (i == 0) begin : g_head
            zp2c_cell u_cell (
               .clock (clock),
               .ctrl  (ctrl),
               .din   (line_out[j]),
               .coef  (coef),
               .dout  (cell_q[j][i]),
               .prod  (prod[j][i])
            );
         end else begin : g_body
            zp2c_cell u_cell (
               .clock (clock),
               .ctrl  (ctrl),
               .din   (cell_q[j][i-1]),
               .coef  (coef),
               .dout  (cell_q[j][i]),
               .prod  (prod[j][i])
            );
         end
      end
   end

   // ---------------- stage D: row sums; output register ----------------
   logic    d_res_ff, d_last_ff;
   sum_type d_sum_ff [0:ROWS-1];
   sum_type row_sum  [0:ROWS-1];
   sum_type grand;
   logic    rsp_valid_ff, rsp_last_ff;
   sum_type rsp_value_ff;

   always_comb begin
      for (int j = 0; j < ROWS; j++) begin
         row_sum[j] = '0;
         for (int i = 0; i < ROWS; i++) begin
            row_sum[j] = row_sum[j] + SUM_W'(prod[j][i]);
         end
      end
      grand = '0;
      for (int j = 0; j < ROWS; j++) begin
         grand = grand + d_sum_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_res_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         d_res_ff     <= c_res_ff;
         rsp_valid_ff <= d_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_last_ff    <= c_last_ff;
         rsp_last_ff  <= d_last_ff;
         rsp_value_ff <= grand;
         for (int j = 0; j < ROWS; j++) begin
            d_sum_ff[j] <= row_sum[j];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_last_of_frame  = rsp_last_ff;

   // ---------------- assertions ----------------
   `ZP2C_ASSERT_NEXT(a_res_follows_due, accept && res, a_val_ff && a_res_ff, "result beat lost at stage A")
   `ZP2C_ASSERT_NEXT(pos_clear_at_end, accept && (last || overrun), (p_ff == '0) && (q_ff == '0) && (r_ff == '0) && (c_ff == '0), "positions not cleared at frame end")
   `ZP2C_ASSERT_NEXT(stall_freezes_pipe, !adv, $stable(b_res_ff) && $stable(c_res_ff) && $stable(d_res_ff), "pipeline moved under stall")
   `ZP2C_ASSERT_IMPL(a_res_needs_item, a_res_ff, a_val_ff, "result flag without an item")

endmodule

FILE: dv/correlation_scoreboard.sv
// Scoreboard for the 2-D correlation block: watches the channels, predicts and checks results.
`timescale 1ns / 1ps
module correlation_scoreboard (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_func,
   input  zp2c_pkg::sample_type   req_sample,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  zp2c_pkg::sum_type      rsp_filtered_value,
   input  logic                   rsp_last_of_frame,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  zp2c_pkg::csr_idx_type  csr_index,
   input  zp2c_pkg::coef_row_type csr_data,
   output int                     failures,
   output int                     pending
);
   import zp2c_pkg::*;

   localparam int WIDTH_CAP   = 1024;
   localparam int HEIGHT_CAP  = 1024;
   localparam int KERNEL_CAP  = 5;
   localparam int STORE_DEPTH = 2 * (KERNEL_CAP / 2) * (WIDTH_CAP + 1) + 1;

   typedef struct {
      sum_type value;
      logic    last;
   } pixel_result_type;

   logic [KSIZE_W-1:0] tap_count;
   logic [DIM_W-1:0]   image_width;
   logic [DIM_W-1:0]   image_height;
   coef_row_type       coef_rows [COEF_ROWS];
   sample_type         pixel_store [STORE_DEPTH];
   int unsigned        in_pos;
   int unsigned        out_pos;
   pixel_result_type   expected_pixels [$];

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // one input beat: store the sample and, once the window is primed, predict a result
   function automatic void correlate_beat(logic func, sample_type s);
      int unsigned      ks, w, ht, h, total, delay, q, r, c;
      int               mr, mc;
      longint           acc;
      coef_type         tap;
      sample_type       v;
      pixel_result_type res;
      ks    = clampu(tap_count, 1, KERNEL_CAP);
      w     = clampu(image_width, 1, WIDTH_CAP);
      ht    = clampu(image_height, 1, HEIGHT_CAP);
      h     = ks / 2;
      total = w * ht;
      delay = h * w + h;
      v     = (!func && in_pos < total) ? s : '0;
      pixel_store[in_pos % STORE_DEPTH] = v;
      if (in_pos < delay) begin
         in_pos++;
         return;
      end
      in_pos++;
      q = out_pos;
      if (q >= total) begin
         in_pos  = 0;
         out_pos = 0;
         return;
      end
      r   = q / w;
      c   = q % w;
      acc = 0;
      for (int k = 0; k < ks; k++) begin
         mr = int'(r) + k - int'(h);
         if (mr < 0 || mr >= int'(ht)) continue;
         for (int l = 0; l < ks; l++) begin
            mc = int'(c) + l - int'(h);
            if (mc < 0 || mc >= int'(w)) continue;
            tap = coef_rows[k][12*l +: 12];
            acc += longint'(pixel_store[(mr * w + mc) % STORE_DEPTH]) * longint'(tap);
         end
      end
      res.value = acc[31:0];
      res.last  = (q == total - 1);
      expected_pixels.push_back(res);
      if (res.last) begin
         in_pos  = 0;
         out_pos = 0;
      end else begin
         out_pos = q + 1;
      end
   endfunction

   always @(posedge clock) begin
      pixel_result_type e;
      if (reset) begin
         tap_count    = 3;
         image_width  = 1024;
         image_height = 1024;
         foreach (coef_rows[i]) coef_rows[i] = '0;
         foreach (pixel_store[i]) pixel_store[i] = '0;
         in_pos  = 0;
         out_pos = 0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result beat: filtered_value %0d", rsp_filtered_value);
               failures++;
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_filtered_value !== e.value) begin
                  $error("filtered_value: expected %0d, actual %0d", e.value, rsp_filtered_value);
                  failures++;
               end
               if (rsp_last_of_frame !== e.last) begin
                  $error("last_of_frame: expected %0b, actual %0b", e.last, rsp_last_of_frame);
                  failures++;
               end
            end
         end
         // a beat taken at this edge still sees the old registers
         if (req_valid && req_ready) correlate_beat(req_func, req_sample);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TAP_COUNT:    tap_count    = csr_data[KSIZE_W-1:0];
               CSR_IMAGE_WIDTH:  image_width  = csr_data[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: image_height = csr_data[DIM_W-1:0];
               default:          coef_rows[csr_index - CSR_COEF_ROW0] = csr_data;
            endcase
         end
      end
      pending = expected_pixels.size();
   end

   initial begin
      failures = 0;
      pending  = 0;
   end

endmodule

FILE: dv/testbench.sv
// Top of the 2-D correlation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import zp2c_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic         req_func = 1'b0;
   sample_type   req_sample = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   sum_type      rsp_filtered_value;
   logic         rsp_last_of_frame;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   csr_idx_type  csr_index = CSR_TAP_COUNT;
   coef_row_type csr_data = '0;
   int           failures, pending;

   // current frame geometry as the block sees it (after clamping)
   int unsigned  cur_ks = 3, cur_w = 1024, cur_h = 1024;
   int           beats_sent = 0, frames_run = 0;
   bit           steady;  // no idling on either side while set

   always #6 clock = ~clock;

   zero_padded_2d_correlation_top dut (.*);

   correlation_scoreboard scoreboard (.*);

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // receiver: ready high for a while, then a stall
   initial begin
      int g;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(12, 1)) @(negedge clock);
         g = idle_gap();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(logic func, sample_type s);
      int g;
      g = idle_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      beats_sent++;
   endtask

   // returns after valid has been low at a falling edge, so back-to-back writes never collide
   task automatic write_reg(csr_idx_type idx, coef_row_type d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // block idle: valid dropped, every result in, then a further wait
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic set_geometry(int unsigned ks, int unsigned w, int unsigned h);
      wait_idle();
      write_reg(CSR_TAP_COUNT, coef_row_type'(ks));
      write_reg(CSR_IMAGE_WIDTH, coef_row_type'(w));
      write_reg(CSR_IMAGE_HEIGHT, coef_row_type'(h));
      cur_ks = clampu(ks & 7, 1, 5);
      cur_w  = clampu(w & 11'h7ff, 1, 1024);
      cur_h  = clampu(h & 11'h7ff, 1, 1024);
   endtask

   // 0: random taps, 1: all most negative, 2: all most positive, 3: sparse
   task automatic load_kernel(int style);
      coef_row_type row;
      wait_idle();
      for (int k = 0; k < COEF_ROWS; k++) begin
         case (style)
            1:       row = {5{12'h800}};
            2:       row = {5{12'h7ff}};
            3:       row = 60'(12'h100) << (12 * $urandom_range(4));
            default: row = coef_row_type'({$urandom, $urandom});
         endcase
         write_reg(csr_idx_type'(CSR_COEF_ROW0 + k), row);
      end
   endtask

   function automatic sample_type pick_sample(bit extreme);
      if (extreme || $urandom_range(9) == 0) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      return sample_type'($urandom);
   endfunction

   // one frame: the image, then drain beats up to the flagged result;
   // early drains and late samples mixed in as noise
   task automatic run_frame(bit extreme);
      int unsigned total, delay;
      total = cur_w * cur_h;
      delay = (cur_ks / 2) * cur_w + cur_ks / 2;
      for (int unsigned p = 0; p < total + delay; p++) begin
         if (p < total)
            send_beat($urandom_range(19) == 0, pick_sample(extreme));
         else
            send_beat(1'($urandom_range(1)), pick_sample(extreme));
      end
      frames_run++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme taps and samples, every kernel size, clamped registers
      steady = 1'b1;
      load_kernel(1);
      set_geometry(3, 4, 3);
      run_frame(1'b1);
      load_kernel(2);
      run_frame(1'b1);
      steady = 1'b0;
      set_geometry(1, 1, 1);
      run_frame(1'b1);
      set_geometry(5, 1, 1);   // window far larger than the image
      run_frame(1'b0);
      load_kernel(0);
      set_geometry(4, 5, 2);   // even size, centre off the middle
      run_frame(1'b0);
      set_geometry(2, 3, 3);
      run_frame(1'b0);
      set_geometry(0, 0, 0);   // all clamp up to 1
      run_frame(1'b0);
      set_geometry(7, 3, 4);   // clamps down to 5
      run_frame(1'b0);
      set_geometry(1, 2047, 1); // widest row
      run_frame(1'b0);

      // random frames, mostly small
      while (beats_sent < 1900) begin
         steady = ($urandom_range(7) == 0);
         if ($urandom_range(1)) begin
            set_geometry($urandom_range(7), $urandom_range(12), $urandom_range(8));
            load_kernel($urandom_range(5) < 3 ? 0 : $urandom_range(3));
         end
         run_frame($urandom_range(9) == 0);
      end
      steady = 1'b0;
      wait_idle();

      $display("covered %0d frames, %0d request beats, kernel sizes 1..5 incl. clamped regs",
               frames_run, beats_sent);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d results outstanding", pending);
      $display("== FAIL ==");
      $finish;
   end

endmodule
